[rtl/frf_pkg.sv]
// Shared types and constants for the Ethernet UDP/ARP receive frame filter.
`default_nettype none

package frf_pkg;

  // Verdict codes given once per frame
  typedef enum logic [2:0] {
    V_ACCEPT_UDP  = 3'd0,
    V_ARP_HOST    = 3'd1,
    V_ARP_OTHER   = 3'd2,
    V_NOT_IPV4    = 3'd3,
    V_BAD_VERSION = 3'd4,
    V_NOT_UDP     = 3'd5,
    V_WRONG_PORT  = 3'd6,
    V_TRUNCATED   = 3'd7
  } verdict_t;

  // Configuration register indexes
  localparam logic REG_HOST_IP   = 1'b0;
  localparam logic REG_HOST_PORT = 1'b1;

  // Ethertypes as captured (first wire byte in the low half)
  localparam logic [15:0] ETYPE_ARP  = 16'h0608;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0008;
  localparam logic [7:0]  VERSION_MASK = 8'hF0;
  localparam logic [3:0]  IP_VERSION_4 = 4'd4;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;

  // Byte offsets within the frame
  localparam logic [5:0] OFS_ETYPE_LO = 6'd12;
  localparam logic [5:0] OFS_ETYPE_HI = 6'd13;
  localparam logic [5:0] OFS_VERSION  = 6'd14;
  localparam logic [5:0] OFS_PROTO    = 6'd23;
  localparam logic [5:0] OFS_PORT_HI  = 6'd36;
  localparam logic [5:0] OFS_PORT_LO  = 6'd37;
  localparam logic [5:0] OFS_ARP_0    = 6'd38;
  localparam logic [5:0] OFS_ARP_1    = 6'd39;
  localparam logic [5:0] OFS_ARP_2    = 6'd40;
  localparam logic [5:0] OFS_ARP_3    = 6'd41;
  localparam logic [5:0] POS_MAX      = 6'd63;

  // Captured header of one finished frame, handed from front to back
  typedef struct packed {
    logic [15:0] ethertype;
    logic [3:0]  version;
    logic [7:0]  protocol;
    logic [15:0] dest_port;
    logic [31:0] arp_target;
    logic [5:0]  last_pos;
  } frame_rec_t;

endpackage

`default_nettype wire

[rtl/frf_front.sv]
// Front end: counts frame bytes, captures header fields, emits one record per frame.
`default_nettype none

module frf_front import frf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output frame_rec_t      rec,
  output logic            rec_valid
);

  logic [5:0]  byte_index, byte_index_next;
  logic [15:0] ethertype, ethertype_next;
  logic [3:0]  version, version_next;
  logic [7:0]  protocol, protocol_next;
  logic [15:0] dest_port, dest_port_next;
  logic [31:0] arp_target, arp_target_next;

  // Capture at fixed offsets, current byte included
  always_comb begin
    ethertype_next  = ethertype;
    version_next    = version;
    protocol_next   = protocol;
    dest_port_next  = dest_port;
    arp_target_next = arp_target;
    case (byte_index)
      OFS_ETYPE_LO: ethertype_next = {ethertype[15:8], in_byte};
      OFS_ETYPE_HI: ethertype_next = {in_byte, ethertype[7:0]};
      OFS_VERSION:  version_next   = 4'((in_byte & VERSION_MASK) >> 4);
      OFS_PROTO:    protocol_next  = in_byte;
      OFS_PORT_HI:  dest_port_next = {in_byte, dest_port[7:0]};
      OFS_PORT_LO:  dest_port_next = {dest_port[15:8], in_byte};
      OFS_ARP_0, OFS_ARP_1, OFS_ARP_2, OFS_ARP_3:
        arp_target_next = {arp_target[23:0], in_byte};
      default: ;
    endcase
    byte_index_next = (byte_index == POS_MAX) ? byte_index : byte_index + 6'd1;
  end

  // Record for the back end on the last byte
  always_comb begin
    rec.ethertype  = ethertype_next;
    rec.version    = version_next;
    rec.protocol   = protocol_next;
    rec.dest_port  = dest_port_next;
    rec.arp_target = arp_target_next;
    rec.last_pos   = byte_index;
    rec_valid      = in_valid && in_last;
  end

  // Frame state; cleared after each frame
  always_ff @(posedge clk) begin
    if (rst || (in_valid && in_last)) begin
      byte_index <= '0;
      ethertype  <= '0;
      version    <= '0;
      protocol   <= '0;
      dest_port  <= '0;
      arp_target <= '0;
    end else if (in_valid) begin
      byte_index <= byte_index_next;
      ethertype  <= ethertype_next;
      version    <= version_next;
      protocol   <= protocol_next;
      dest_port  <= dest_port_next;
      arp_target <= arp_target_next;
    end
  end

endmodule

`default_nettype wire

[rtl/frf_queue.sv]
// Two-entry queue of frame records between front and back ends.
`default_nettype none

module frf_queue import frf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire frame_rec_t wr_rec,
  output logic            full,
  input  wire logic       rd_en,
  output frame_rec_t      rd_rec,
  output logic            rd_valid
);

  frame_rec_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_rec   = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/frf_back.sv]
// Back end: turns a frame record into a verdict and holds it in the output register.
`default_nettype none

module frf_back import frf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire frame_rec_t  rec,
  input  wire logic        rec_valid,
  output logic             rec_take,
  input  wire logic [31:0] host_ip,
  input  wire logic [15:0] host_port,
  output logic             out_valid,
  input  wire logic        out_pop,
  output verdict_t         out_verdict
);

  verdict_t verdict_next;

  // Ordered checks; pos < N means the frame ended before byte N
  always_comb begin
    if (rec.last_pos < OFS_ETYPE_HI) begin
      verdict_next = V_TRUNCATED;
    end else if (rec.ethertype == ETYPE_ARP) begin
      if (rec.last_pos < OFS_ARP_3) verdict_next = V_TRUNCATED;
      else if (rec.arp_target == host_ip) verdict_next = V_ARP_HOST;
      else verdict_next = V_ARP_OTHER;
    end else if (rec.ethertype != ETYPE_IPV4) begin
      verdict_next = V_NOT_IPV4;
    end else if (rec.last_pos < OFS_VERSION) begin
      verdict_next = V_TRUNCATED;
    end else if (rec.version != IP_VERSION_4) begin
      verdict_next = V_BAD_VERSION;
    end else if (rec.last_pos < OFS_PROTO) begin
      verdict_next = V_TRUNCATED;
    end else if (rec.protocol != PROTO_UDP) begin
      verdict_next = V_NOT_UDP;
    end else if (rec.last_pos < OFS_PORT_LO) begin
      verdict_next = V_TRUNCATED;
    end else if (rec.dest_port != host_port) begin
      verdict_next = V_WRONG_PORT;
    end else begin
      verdict_next = V_ACCEPT_UDP;
    end
  end

  // Take a record when the output register is free or being drained
  assign rec_take = rec_valid && (!out_valid || out_pop);

  always_ff @(posedge clk) begin
    if (rec_take) out_verdict <= verdict_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_take) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/eth_udp_arp_frame_filter.sv]
// Ethernet UDP/ARP receive frame filter: top level with configuration registers.
//
// Input side is a queue: present data_byte/last_byte with push; a byte is
// transferred when push is high and full is low. Bytes start at the
// destination MAC, one per cycle at line rate while full is low.
// Result side is a queue: while empty is low, verdict holds one verdict per
// frame, oldest first; it is transferred when pop is high and empty is low.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 host IP, 1 host UDP
// port) and cfg_data; cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle while full is low, frames back to back, including
// one-byte frames. The verdict passes through the record queue write, then the
// verdict register, and waits in the queue while the verdict register is occupied.
// Stall: a two-entry record queue and the verdict register hold up to
// three verdicts; once all three are in use full rises and stays high until pop.
// Reset clears frame state, queue and registers; host address and port reset
// to zero.
`default_nettype none

module eth_udp_arp_frame_filter import frf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       verdict,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] host_ip_address;
  logic [15:0] host_udp_port;
  frame_rec_t  front_rec;
  logic        front_rec_valid;
  frame_rec_t  q_rec;
  logic        q_valid;
  logic        q_take;
  logic        out_valid;
  verdict_t    out_verdict;
  logic        in_xfer;

  assign cfg_ready = 1'b1;
  assign in_xfer   = push && !full;
  assign empty     = !out_valid;
  assign verdict   = out_verdict;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      host_ip_address <= '0;
      host_udp_port   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOST_IP:   host_ip_address <= cfg_data;
        REG_HOST_PORT: host_udp_port   <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  frf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_xfer),
    .in_byte   (data_byte),
    .in_last   (last_byte),
    .rec       (front_rec),
    .rec_valid (front_rec_valid)
  );

  frf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_rec_valid),
    .wr_rec   (front_rec),
    .full     (full),
    .rd_en    (q_take),
    .rd_rec   (q_rec),
    .rd_valid (q_valid)
  );

  frf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rec         (q_rec),
    .rec_valid   (q_valid),
    .rec_take    (q_take),
    .host_ip     (host_ip_address),
    .host_port   (host_udp_port),
    .out_valid   (out_valid),
    .out_pop     (pop),
    .out_verdict (out_verdict)
  );

endmodule

`default_nettype wire

[test/tb_eth_udp_arp_frame_filter.sv]
// Testbench for the Ethernet UDP/ARP frame filter: streams frames in, predicts and checks verdicts.
`timescale 1ns / 1ps

module tb_eth_udp_arp_frame_filter;
  import frf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int CUT_LENGTHS[9] = '{13, 14, 15, 23, 24, 37, 38, 41, 42};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        pop       = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        full;
  logic        empty;
  logic [2:0]  verdict;
  logic        cfg_ready;

  eth_udp_arp_frame_filter dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .empty     (empty),
    .pop       (pop),
    .verdict   (verdict),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bytes waiting to be sent, and verdicts still owed by the block
  frame_byte_t pending_bytes[$];
  verdict_t    expected_verdicts[$];
  verdict_t    wanted_verdict;
  int          queued_bytes  = 0;
  int          moved_bytes   = 0;
  int          error_count   = 0;
  int          cycle_count   = 0;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;

  // Predictor copy of the host registers and of the header being captured
  logic [31:0] host_ip_cfg   = '0;
  logic [15:0] host_port_cfg = '0;
  logic [5:0]  rx_pos        = '0;
  logic [15:0] rx_etype      = '0;
  logic [3:0]  rx_version    = '0;
  logic [7:0]  rx_proto      = '0;
  logic [15:0] rx_port       = '0;
  logic [31:0] rx_target     = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Verdict for a frame of len bytes; a check needing byte N truncates if len <= N
  function automatic verdict_t judge_frame(input int len);
    if (len <= int'(OFS_ETYPE_HI)) return V_TRUNCATED;
    if (rx_etype == ETYPE_ARP) begin
      if (len <= int'(OFS_ARP_3)) return V_TRUNCATED;
      return (rx_target == host_ip_cfg) ? V_ARP_HOST : V_ARP_OTHER;
    end
    if (rx_etype != ETYPE_IPV4) return V_NOT_IPV4;
    if (len <= int'(OFS_VERSION)) return V_TRUNCATED;
    if (rx_version != IP_VERSION_4) return V_BAD_VERSION;
    if (len <= int'(OFS_PROTO)) return V_TRUNCATED;
    if (rx_proto != PROTO_UDP) return V_NOT_UDP;
    if (len <= int'(OFS_PORT_LO)) return V_TRUNCATED;
    if (rx_port != host_port_cfg) return V_WRONG_PORT;
    return V_ACCEPT_UDP;
  endfunction

  // Capture one transferred byte; on the last byte queue the verdict and clear
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int len;
    case (rx_pos)
      OFS_ETYPE_LO: rx_etype[7:0]  = b;
      OFS_ETYPE_HI: rx_etype[15:8] = b;
      OFS_VERSION:  rx_version     = 4'((b & VERSION_MASK) >> 4);
      OFS_PROTO:    rx_proto       = b;
      OFS_PORT_HI:  rx_port[15:8]  = b;
      OFS_PORT_LO:  rx_port[7:0]   = b;
      OFS_ARP_0, OFS_ARP_1, OFS_ARP_2, OFS_ARP_3: rx_target = {rx_target[23:0], b};
      default: ;
    endcase
    len = int'(rx_pos) + 1;
    if (rx_pos != POS_MAX) rx_pos = rx_pos + 6'd1;
    if (last) begin
      expected_verdicts.push_back(judge_frame(len));
      rx_pos     = '0;
      rx_etype   = '0;
      rx_version = '0;
      rx_proto   = '0;
      rx_port    = '0;
      rx_target  = '0;
    end
  endtask

  // Byte driver: holds the current byte until transferred
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        absorb_byte(data_byte, last_byte);
        moved_bytes++;
      end
      if (!push || !full) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          {data_byte, last_byte} <= pending_bytes.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor with random pop stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none expected", verdict));
        end else begin
          wanted_verdict = expected_verdicts.pop_front();
          if (verdict !== wanted_verdict)
            report_mismatch($sformatf("verdict %0d, expected %s",
                                      verdict, wanted_verdict.name()));
        end
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_HOST_IP) host_ip_cfg = val;
    else host_port_cfg = val[15:0];
  endtask

  // Sender holds off until every byte is transferred and every verdict is back
  task automatic wait_drained();
    do @(posedge clk);
    while (moved_bytes != queued_bytes || expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One frame of len bytes, random filler with header fields at their offsets
  task automatic add_frame(input int len, input logic [15:0] etype, input logic [7:0] ver_byte,
                           input logic [7:0] proto, input logic [15:0] port,
                           input logic [31:0] target);
    frame_byte_t fb;
    for (int i = 0; i < len; i++) begin
      fb.data = 8'($urandom);
      case (i)
        int'(OFS_ETYPE_LO): fb.data = etype[7:0];
        int'(OFS_ETYPE_HI): fb.data = etype[15:8];
        int'(OFS_VERSION):  fb.data = ver_byte;
        int'(OFS_PROTO):    fb.data = proto;
        int'(OFS_PORT_HI):  fb.data = port[15:8];
        int'(OFS_PORT_LO):  fb.data = port[7:0];
        int'(OFS_ARP_0):    fb.data = target[31:24];
        int'(OFS_ARP_1):    fb.data = target[23:16];
        int'(OFS_ARP_2):    fb.data = target[15:8];
        int'(OFS_ARP_3):    fb.data = target[7:0];
        default: ;
      endcase
      fb.last = (i == len - 1);
      pending_bytes.push_back(fb);
      queued_bytes++;
    end
  endtask

  // Mostly well-formed ARP and UDP frames, some near misses and plain noise
  task automatic add_random_frames(input int n_bytes);
    int          added;
    int          len;
    logic [15:0] etype;
    logic [7:0]  ver;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [31:0] target;
    added = 0;
    while (added < n_bytes) begin
      etype  = 16'($urandom);
      ver    = 8'($urandom);
      proto  = 8'($urandom);
      port   = 16'($urandom);
      target = $urandom;
      case ($urandom_range(9))
        0, 1, 2: begin
          etype = ETYPE_ARP;
          case ($urandom_range(2))
            0: target = host_ip_cfg;
            1: target = host_ip_cfg ^ (32'hFF << (8 * $urandom_range(3)));
            default: ;
          endcase
        end
        3, 4, 5, 6, 7: begin
          etype = ETYPE_IPV4;
          if ($urandom_range(4) != 0) ver = {IP_VERSION_4, ver[3:0]};
          if ($urandom_range(4) != 0) proto = PROTO_UDP;
          if ($urandom_range(3) != 0) port = host_port_cfg;
          else if ($urandom_range(1) != 0) port = host_port_cfg ^ (16'h1 << $urandom_range(15));
        end
        8: begin
          // one byte of a known ethertype right, the other wrong
          if ($urandom_range(1) != 0) etype = {ETYPE_IPV4[15:8], etype[7:0]};
          else etype = {etype[15:8], ETYPE_ARP[7:0]};
        end
        default: ;
      endcase
      case ($urandom_range(9))
        0, 1:    len = $urandom_range(41, 1);
        2:       len = CUT_LENGTHS[$urandom_range(8)];
        3:       len = $urandom_range(80, 64);
        default: len = $urandom_range(62, 42);
      endcase
      add_frame(len, etype, ver, proto, port, target);
      added += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 32;
    rx_idle_pct = 87;
    write_reg(REG_HOST_IP, 32'hC0A8_0164);
    write_reg(REG_HOST_PORT, 32'h0000_1F90);

    // Directed: every truncation point, each verdict, long frames
    add_frame(1, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'h0);
    add_frame(13, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'h1F90, 32'h0);
    add_frame(42, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_frame(14, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'h0);
    add_frame(14, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'h1F90, 32'h0);
    add_frame(15, ETYPE_IPV4, 8'h65, PROTO_UDP, 16'h1F90, 32'h0);
    add_frame(23, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'h1F90, 32'h0);
    add_frame(24, ETYPE_IPV4, 8'h4F, 8'd6, 16'h1F90, 32'h0);
    add_frame(37, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'h1F90, 32'h0);
    add_frame(38, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'h1F91, 32'h0);
    add_frame(38, ETYPE_IPV4, 8'h40, PROTO_UDP, 16'h1F90, 32'h0);
    add_frame(41, ETYPE_ARP, 8'h45, PROTO_UDP, 16'h1F90, 32'hC0A8_0164);
    add_frame(42, ETYPE_ARP, 8'h00, 8'h00, 16'h0000, 32'hC0A8_0164);
    add_frame(42, ETYPE_ARP, 8'h45, PROTO_UDP, 16'h1F90, 32'hC0A8_0165);
    add_frame(80, ETYPE_IPV4, 8'h4F, PROTO_UDP, 16'h1F90, 32'h0);
    add_frame(70, ETYPE_ARP, 8'hFF, 8'hFF, 16'hFFFF, 32'hC0A8_0164);
    add_frame(1, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'h0);
    wait_drained();

    // Random, all-ones host registers
    write_reg(REG_HOST_IP, 32'hFFFF_FFFF);
    write_reg(REG_HOST_PORT, 32'h0000_FFFF);
    add_random_frames(160);
    wait_drained();

    // Random, stall roles swapped, all-zero host registers
    tx_idle_pct = 87;
    rx_idle_pct = 32;
    write_reg(REG_HOST_IP, 32'h0000_0000);
    write_reg(REG_HOST_PORT, 32'h0000_0000);
    add_random_frames(160);
    wait_drained();

    // Random at full rate, random host registers
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_HOST_IP, $urandom);
    write_reg(REG_HOST_PORT, {16'h0, 16'($urandom)});
    add_random_frames(160);
    wait_drained();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/frf_pkg.sv
rtl/frf_front.sv
rtl/frf_queue.sv
rtl/frf_back.sv
rtl/eth_udp_arp_frame_filter.sv
test/tb_eth_udp_arp_frame_filter.sv
